FILE: rtl/uolt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uolt_pkg
// Shared types and codes for the unique ordered list table.
// ----------------------------------------------------------------------------
package uolt_pkg;

    // position width inside the cell row; covers the largest supported capacity
    localparam int POS_W = 11;

    typedef enum logic [2:0] {
        ACT_READ_AT      = 3'd0,
        ACT_CONTAINS     = 3'd1,
        ACT_INSERT_AT    = 3'd2,
        ACT_INSERT_BACK  = 3'd3,
        ACT_REMOVE_AT    = 3'd4,
        ACT_REMOVE_VALUE = 3'd5,
        ACT_POP_BACK     = 3'd6,
        ACT_CLEAR        = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_FULL   = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        FSM_IDLE  = 1'b0,
        FSM_APPLY = 1'b1
    } fsm_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    // update command broadcast along the row
    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  pos;
    } cell_ctl_t;

    // lookup strobe broadcast along the row when a request beat arrives
    typedef struct packed {
        logic              capture;
        logic [POS_W-1:0]  pick;   // position whose data is gathered
        logic [POS_W-1:0]  count;  // entries currently held
    } probe_t;

endpackage

FILE: rtl/uolt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uolt_cell
// One list slot: holds an entry, compares it against the probe value and
// shifts to/from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module uolt_cell import uolt_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  probe_t                probe,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] cmp_value,
    input  logic [DATA_WIDTH-1:0] ins_value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data_q,
    output logic                  match_q,
    output logic [DATA_WIDTH-1:0] rd_part
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  match_reg, match_next;
    logic                  pick_reg, pick_next;

    always_comb begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INSERT: begin
                if (MY_IDX == ctl.pos) begin
                    data_next = ins_value;
                end else if (MY_IDX > ctl.pos) begin
                    data_next = left_data;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= ctl.pos) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    // only live slots may report a match
    always_comb begin
        match_next = match_reg;
        pick_next  = pick_reg;
        if (probe.capture) begin
            match_next = (MY_IDX < probe.count) && (data_reg == cmp_value);
            pick_next  = (MY_IDX == probe.pick);
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
        pick_reg  <= pick_next;
    end

    assign data_q  = data_reg;
    assign match_q = match_reg;
    assign rd_part = pick_reg ? data_reg : '0;

endmodule

FILE: rtl/unique_ordered_list_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_ordered_list_table_top
// Ordered list of distinct values held in a row of compare/shift cells.
// ----------------------------------------------------------------------------
// Sequencing: a request beat is taken and probed in IDLE; APPLY then updates
//   the row and loads the result register once it is free (two-step control
//   sequencer). No new request is taken until the previous one is applied.
// Reset: aresetn (sync, active low) empties the list and drops any pending
//   result; entry storage is not cleared and holds stale data until written.
// ----------------------------------------------------------------------------
module unique_ordered_list_table_top import uolt_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [2:0] action, [9:3] position, [41:10] value
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [1:0] status, [2] found, [34:3] read_value,
                                   // [41:35] count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    action_t               s_action;
    logic [6:0]            s_position;
    logic [63:0]           s_value64;
    logic [DATA_WIDTH-1:0] s_value;

    assign s_action   = action_t'(s_tdata[2:0]);
    assign s_position = s_tdata[9:3];
    assign s_value64  = 64'(s_tdata[41:10]);
    assign s_value    = s_value64[DATA_WIDTH-1:0];

    // ------------------------------------------------------------------
    // Control sequencer: IDLE takes a beat and probes the row,
    // APPLY updates the row once the result register is free.
    // ------------------------------------------------------------------
    fsm_state_t state_reg, state_next;
    logic       out_free;
    logic       in_beat;
    logic       apply_go;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [47:0]           m_tdata_reg, m_tdata_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:  if (s_tvalid) state_next = FSM_APPLY;
            FSM_APPLY: if (out_free) state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        apply_go = 1'b0;
        case (state_reg)
            FSM_IDLE:  s_tready = 1'b1;
            FSM_APPLY: apply_go = out_free;
            default: begin
                s_tready = 1'b0;
                apply_go = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Held request and list length
    // ------------------------------------------------------------------
    action_t               act_reg, act_next;
    logic [6:0]            pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    always_comb begin
        act_next = act_reg;
        pos_next = pos_reg;
        val_next = val_reg;
        if (in_beat) begin
            act_next = s_action;
            pos_next = s_position;
            val_next = s_value;
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    probe_t                probe;
    cell_ctl_t             ctl_calc, ctl;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;

    // pop reads the last live entry, the rest read at the given position
    assign probe.capture = in_beat;
    assign probe.pick    = (s_action == ACT_POP_BACK) ? POS_W'(count_reg - CNT_W'(1))
                                                      : POS_W'(s_position);
    assign probe.count   = POS_W'(count_reg);

    assign ctl.op  = apply_go ? ctl_calc.op : CELL_HOLD;
    assign ctl.pos = ctl_calc.pos;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        uolt_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .probe      (probe),
            .ctl        (ctl),
            .cmp_value  (s_value),
            .ins_value  (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data_q     (cell_data[i]),
            .match_q    (cell_match[i]),
            .rd_part    (cell_rd[i])
        );
    end

    // values are distinct, so the match vector is one-hot or empty: its index is
    // a plain OR encode; the gathered data is a plain OR as only the picked slot drives it
    logic                  any_match;
    logic [POS_W-1:0]      match_idx;
    logic [DATA_WIDTH-1:0] gather;

    assign any_match = |cell_match;

    always_comb begin
        match_idx = '0;
        gather    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            for (int b = 0; b < POS_W; b++) begin
                if (((i >> b) & 1) == 1) begin
                    match_idx[b] = match_idx[b] | cell_match[i];
                end
            end
            gather = gather | cell_rd[i];
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [POS_W-1:0]      pos_ext, cnt_ext, ins_pos;
    logic                  is_full;
    status_t               res_status;
    logic                  res_found;
    logic [DATA_WIDTH-1:0] res_rd;
    logic [CNT_W-1:0]      res_count;
    logic [63:0]           res_rd64;

    assign pos_ext = POS_W'(pos_reg);
    assign cnt_ext = POS_W'(count_reg);
    assign is_full = (count_reg == CNT_W'(CAPACITY));
    assign ins_pos = (act_reg == ACT_INSERT_BACK) ? cnt_ext : pos_ext;

    always_comb begin
        res_status   = STAT_OK;
        res_found    = 1'b0;
        res_rd       = '0;
        res_count    = count_reg;
        ctl_calc.op  = CELL_HOLD;
        ctl_calc.pos = pos_ext;
        case (act_reg)
            ACT_READ_AT: begin
                if (pos_ext < cnt_ext) begin
                    res_rd = gather;
                end else begin
                    res_status = STAT_REJECT;
                end
            end
            ACT_CONTAINS: begin
                res_found = any_match;
            end
            ACT_INSERT_AT, ACT_INSERT_BACK: begin
                // duplicate and range checks win over full
                if (any_match || (ins_pos > cnt_ext)) begin
                    res_status = STAT_REJECT;
                end else if (is_full) begin
                    res_status = STAT_FULL;
                end else begin
                    ctl_calc.op  = CELL_INSERT;
                    ctl_calc.pos = ins_pos;
                    res_count    = count_reg + CNT_W'(1);
                end
            end
            ACT_REMOVE_AT: begin
                if (pos_ext < cnt_ext) begin
                    res_rd       = gather;
                    ctl_calc.op  = CELL_DELETE;
                    ctl_calc.pos = pos_ext;
                    res_count    = count_reg - CNT_W'(1);
                end else begin
                    res_status = STAT_REJECT;
                end
            end
            ACT_REMOVE_VALUE: begin
                if (any_match) begin
                    ctl_calc.op  = CELL_DELETE;
                    ctl_calc.pos = match_idx;
                    res_count    = count_reg - CNT_W'(1);
                end else begin
                    res_status = STAT_REJECT;
                end
            end
            ACT_POP_BACK: begin
                if (count_reg != '0) begin
                    res_rd    = gather;
                    res_count = count_reg - CNT_W'(1);
                end else begin
                    res_status = STAT_REJECT;
                end
            end
            ACT_CLEAR: begin
                res_count = '0;
            end
            default: begin
                res_status = STAT_OK;
            end
        endcase
    end

    assign res_rd64   = 64'(res_rd);
    assign count_next = apply_go ? res_count : count_reg;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (apply_go) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, 7'(res_count), res_rd64[31:0], res_found, res_status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_beat_to_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == FSM_APPLY))
        else $error("accepted beat not followed by apply");

    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_APPLY) |-> $onehot0(cell_match))
        else $error("value held in more than one slot");

    a_full_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply_go && (res_status == STAT_FULL)) |-> is_full)
        else $error("full status with room left");

    a_found_contains: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply_go && res_found) |-> (act_reg == ACT_CONTAINS))
        else $error("found flag on a non-lookup request");

endmodule
